// ----- hw/rtl/sapd_pkg.sv -----
package sapd_pkg;

  // field widths
  localparam int ANGLE_WIDTH = 20;
  localparam int TIME_WIDTH  = 32;

  // framing constants
  localparam int SYNC_ZEROS = 5;
  localparam int SHORT_LEN  = 15;
  localparam int LONG_LEN   = 24;
  localparam int CHECK_STEP = 4;
  localparam int POS_WIDTH  = 5;
  localparam int RUN_WIDTH  = 3;
  localparam int VALUE_BITS = 12;
  localparam int DELTA_BITS = 6;

  localparam logic signed [ANGLE_WIDTH-1:0] X_RESET = ANGLE_WIDTH'(2048);
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX =
    {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN =
    {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

  // axis codes
  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;

  // long packet commands
  localparam logic [2:0] LCMD_SET_Y = 3'd0;
  localparam logic [2:0] LCMD_SET_X = 3'd1;

  // short packet commands
  localparam logic [1:0] SCMD_ADD_Y = 2'd0;
  localparam logic [1:0] SCMD_SUB_Y = 2'd1;
  localparam logic [1:0] SCMD_ADD_X = 2'd2;
  localparam logic [1:0] SCMD_SUB_X = 2'd3;

  typedef struct packed {
    logic                  line_bit;
    logic [TIME_WIDTH-1:0] sample_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] x_angle;
    logic signed [ANGLE_WIDTH-1:0] y_angle;
    logic [TIME_WIDTH-1:0]         packet_time;
    logic [1:0]                    last_axis;
    logic                          check_error;
  } out_beat_t;

  // true if any check bit equals the bit before it
  function automatic logic check_fail(input logic [LONG_LEN-1:0] bits,
                                      input logic is_long);
    logic fail;
    fail = 1'b0;
    for (int i = CHECK_STEP; i < LONG_LEN; i += CHECK_STEP) begin
      if ((is_long || i < SHORT_LEN) && bits[i] == bits[i-1]) begin
        fail = 1'b1;
      end
    end
    return fail;
  endfunction

  // add or subtract a small unsigned delta with saturation
  function automatic logic signed [ANGLE_WIDTH-1:0] sat_step(
      input logic signed [ANGLE_WIDTH-1:0] base,
      input logic [DELTA_BITS-1:0]         delta,
      input logic                          sub);
    logic signed [ANGLE_WIDTH:0] ext;
    logic signed [ANGLE_WIDTH:0] dext;
    logic signed [ANGLE_WIDTH:0] sum;
    ext  = {base[ANGLE_WIDTH-1], base};
    dext = {{(ANGLE_WIDTH+1-DELTA_BITS){1'b0}}, delta};
    sum  = sub ? (ext - dext) : (ext + dext);
    if (sum[ANGLE_WIDTH] != sum[ANGLE_WIDTH-1]) begin
      return sum[ANGLE_WIDTH] ? ANGLE_MIN : ANGLE_MAX;
    end
    return sum[ANGLE_WIDTH-1:0];
  endfunction

endpackage

// ----- hw/rtl/serial_angle_packet_deframer_unit.sv -----
// Serial angle packet deframer. One line bit is accepted per clock cycle while
// in_stall is low; bits that only sync, skip or fill a packet cost nothing
// beyond that cycle. The bit that completes a packet is decoded in the same
// cycle it is taken; any result beat is registered into the output register,
// or into the skid register if the output register is held. The two-entry
// output buffer lets the input keep running while one result waits; in_stall
// rises only when both entries are full. No clearing pass is needed after reset.
module serial_angle_packet_deframer_unit import sapd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // framing state
  logic [RUN_WIDTH-1:0]          zero_run;
  logic                          synced;
  logic                          in_packet;
  logic [POS_WIDTH-1:0]          bit_position;
  logic [LONG_LEN-1:0]           packet_bits;
  logic [TIME_WIDTH-1:0]         start_time;
  logic signed [ANGLE_WIDTH-1:0] x_value;
  logic signed [ANGLE_WIDTH-1:0] y_value;
  logic [1:0]                    axis_mark;
  logic                          any_emitted;

  // output buffer
  out_beat_t skid_data;
  logic      skid_valid;

  logic accept;
  logic out_fire;
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // packet bits including the current beat
  logic [LONG_LEN-1:0]  bits_next;
  logic [POS_WIDTH-1:0] pos_next;
  logic                 is_long;
  logic                 done;
  always_comb begin
    bits_next = packet_bits;
    if (bit_position < POS_WIDTH'(LONG_LEN)) begin
      bits_next[bit_position[POS_WIDTH-1:0]] = in_data.line_bit;
    end
    pos_next = bit_position + POS_WIDTH'(1);
    is_long  = bits_next[1];
    done     = pos_next >= (is_long ? POS_WIDTH'(LONG_LEN) : POS_WIDTH'(SHORT_LEN));
  end

  // field extraction
  logic [2:0]            lcmd;
  logic [1:0]            scmd;
  logic [VALUE_BITS-1:0] lvalue;
  logic [DELTA_BITS-1:0] sdelta;
  logic                  fail;
  assign lcmd   = {bits_next[5], bits_next[3], bits_next[2]};
  assign scmd   = {bits_next[3], bits_next[2]};
  assign lvalue = {bits_next[21], bits_next[19], bits_next[18], bits_next[17],
                   bits_next[15], bits_next[14], bits_next[13], bits_next[11],
                   bits_next[10], bits_next[9], bits_next[7], bits_next[6]};
  assign sdelta = {bits_next[11], bits_next[10], bits_next[9],
                   bits_next[7], bits_next[6], bits_next[5]};
  assign fail   = check_fail(bits_next, is_long);

  // packet decode
  logic signed [ANGLE_WIDTH-1:0] x_next;
  logic signed [ANGLE_WIDTH-1:0] y_next;
  logic [1:0]                    axis_next;
  logic                          emit;
  logic                          apply;
  always_comb begin
    x_next    = x_value;
    y_next    = y_value;
    axis_next = axis_mark;
    emit      = 1'b0;
    apply     = 1'b0;
    if (accept && synced && in_packet && done) begin
      if (fail) begin
        emit = 1'b1;
      end else if (is_long) begin
        emit  = 1'b1;
        apply = 1'b1;
        if (lcmd == LCMD_SET_Y) begin
          y_next    = {{(ANGLE_WIDTH-VALUE_BITS){1'b0}}, lvalue};
          axis_next = AXIS_Y;
        end else if (lcmd == LCMD_SET_X) begin
          x_next    = {{(ANGLE_WIDTH-VALUE_BITS){1'b0}}, lvalue};
          axis_next = AXIS_X;
        end
      end else if (any_emitted) begin
        emit  = 1'b1;
        apply = 1'b1;
        case (scmd)
          SCMD_ADD_Y: begin
            y_next    = sat_step(y_value, sdelta, 1'b0);
            axis_next = AXIS_Y;
          end
          SCMD_SUB_Y: begin
            y_next    = sat_step(y_value, sdelta, 1'b1);
            axis_next = AXIS_Y;
          end
          SCMD_ADD_X: begin
            x_next    = sat_step(x_value, sdelta, 1'b0);
            axis_next = AXIS_X;
          end
          default: begin
            x_next    = sat_step(x_value, sdelta, 1'b1);
            axis_next = AXIS_X;
          end
        endcase
      end
    end
  end

  out_beat_t result;
  always_comb begin
    result.x_angle     = x_next;
    result.y_angle     = y_next;
    result.packet_time = start_time;
    result.last_axis   = axis_next;
    result.check_error = fail;
  end

  // framing and angle state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run     <= '0;
      synced       <= 1'b0;
      in_packet    <= 1'b0;
      bit_position <= '0;
      packet_bits  <= '0;
      start_time   <= '0;
      x_value      <= X_RESET;
      y_value      <= '0;
      axis_mark    <= AXIS_NONE;
      any_emitted  <= 1'b0;
    end else if (accept) begin
      if (!synced) begin
        if (in_data.line_bit) begin
          zero_run <= '0;
        end else if (zero_run + RUN_WIDTH'(1) >= RUN_WIDTH'(SYNC_ZEROS)) begin
          zero_run <= RUN_WIDTH'(SYNC_ZEROS);
          synced   <= 1'b1;
        end else begin
          zero_run <= zero_run + RUN_WIDTH'(1);
        end
      end else if (!in_packet) begin
        if (in_data.line_bit) begin
          in_packet    <= 1'b1;
          packet_bits  <= LONG_LEN'(1);
          bit_position <= POS_WIDTH'(1);
          start_time   <= in_data.sample_time;
        end
      end else begin
        packet_bits <= bits_next;
        if (done) begin
          in_packet    <= 1'b0;
          bit_position <= '0;
        end else begin
          bit_position <= pos_next;
        end
        if (apply) begin
          x_value     <= x_next;
          y_value     <= y_next;
          axis_mark   <= axis_next;
          any_emitted <= 1'b1;
        end
      end
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          skid_valid <= 1'b0;
        end
      end else if (emit) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (emit) begin
      if (!out_valid || out_fire) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  // skid entry only holds a beat behind the output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // a packet is only collected once synchronized
  assert property (@(posedge clk) disable iff (rst) in_packet |-> synced)
    else $error("packet collection before sync");

  // bit position stays inside the long packet and is zero between packets
  assert property (@(posedge clk) disable iff (rst)
    (bit_position < POS_WIDTH'(LONG_LEN)) && (in_packet || bit_position == '0))
    else $error("bit position out of range");

  // a delivered beat never carries an undefined axis code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_axis != 2'd3))
    else $error("bad axis code on output");

endmodule
